### hdl/i2cmbw_pkg.sv
// Shared types and constants for the I2C write-only master pin sequencer.
package i2cmbw_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE + 1);

   // Bit slot after the last data bit: the acknowledge clock.
   localparam logic [BIT_CNT_W-1:0] ACK_SLOT = BIT_CNT_W'(BITS_PER_BYTE);

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_STOP  = 2'd1,
      KIND_WRITE = 2'd2
   } kind_type;

   // Three pin phases per step: set data, clock high, clock low.
   typedef enum logic [1:0] {
      PH_SET  = 2'd0,
      PH_HIGH = 2'd1,
      PH_LOW  = 2'd2
   } phase_type;

   typedef struct packed {
      kind_type                 kind;
      logic [BITS_PER_BYTE-1:0] data_byte;
      logic                     sda_sample;
   } cmd_type;

endpackage

### hdl/i2cmbw_if.sv
// Request and response channel interfaces of the I2C master pin sequencer.
interface i2cmbw_req_if;
   import i2cmbw_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               kind;
   logic [BITS_PER_BYTE-1:0] data_byte;
   logic                     sda_sample;

   modport source (output valid, output kind, output data_byte, output sda_sample,
                   input ready);
   modport sink (input valid, input kind, input data_byte, input sda_sample,
                 output ready);
endinterface

interface i2cmbw_rsp_if;
   logic valid;
   logic ready;
   logic scl_level;
   logic sda_level;
   logic sda_drive;
   logic ack_level;
   logic last_phase;

   modport source (output valid, output scl_level, output sda_level, output sda_drive,
                   output ack_level, output last_phase, input ready);
   modport sink (input valid, input scl_level, input sda_level, input sda_drive,
                 input ack_level, input last_phase, output ready);
endinterface

### hdl/i2c_master_byte_writer_unit.sv
// Write-only I2C master: one pin phase per response, one response per clock at best.
// Each request is start, stop or write byte. A start or a stop gives three responses, a
// byte write gives 27 (three per data bit, then release, acknowledge clock and
// re-drive), the last one flagged and, for a write, carrying the acknowledge level
// taken from the request (1 means no acknowledge). An unused kind is taken and gives no
// response. The back-end sequencer emits one phase per cycle while responses are taken,
// so a write occupies it for 27 phases and a start or stop for 3; requests queue ahead
// of it in a QUEUE_DEPTH-entry command queue and are taken while that queue has room.
// A finished phase sits in an output register; the next phase is formed in the cycle
// that response is taken, and the sequencer holds for as long as the response waits.
module i2c_master_byte_writer_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   i2cmbw_req_if.sink   req_bus,
   i2cmbw_rsp_if.source rsp_bus
);
   import i2cmbw_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   i2cmbw_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   i2cmbw_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp_bus)
   );

endmodule

### hdl/i2cmbw_front.sv
// Request front end: accepts requests, drops unused kinds, queues commands.
module i2cmbw_front #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   i2cmbw_req_if.sink          req,
   output logic                cmd_valid,
   output i2cmbw_pkg::cmd_type cmd,
   input  logic                cmd_pop
);
   import i2cmbw_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             is_cmd;
   logic             push;
   cmd_type          new_cmd;

   assign req.ready = (count_ff != FULL_CNT);
   assign is_cmd    = req.kind inside {KIND_START, KIND_STOP, KIND_WRITE};
   // Drop an unused kind: it is taken but never reaches the sequencer.
   assign push      = req.valid && req.ready && is_cmd;

   assign new_cmd.kind       = kind_type'(req.kind);
   assign new_cmd.data_byte  = req.data_byte;
   assign new_cmd.sda_sample = req.sda_sample;

   assign cmd_valid = (count_ff != '0);
   assign cmd       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> count_ff != '0)
      else $error("command popped from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push && !cmd_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queued command not counted");

endmodule

### hdl/i2cmbw_seq.sv
// Pin sequencer: walks one queued command through its pin phases.
module i2cmbw_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  i2cmbw_pkg::cmd_type cmd,
   output logic                cmd_pop,
   i2cmbw_rsp_if.source        rsp
);
   import i2cmbw_pkg::*;

   logic                     busy_ff;
   kind_type                 kind_ff;
   logic [BITS_PER_BYTE-1:0] byte_ff;
   logic                     ack_ff;
   phase_type                sub_ff;
   logic [BIT_CNT_W-1:0]     bit_ff;

   // Bus line state.
   logic scl_ff, scl_in;
   logic sda_ff, sda_in;
   logic drv_ff, drv_in;
   logic ack_in;

   logic out_valid_ff;
   logic out_scl_ff, out_sda_ff, out_drv_ff, out_ack_ff, out_last_ff;

   logic step;
   logic last;

   assign step    = busy_ff && (!out_valid_ff || rsp.ready);
   assign last    = (sub_ff == PH_LOW) && ((kind_ff != KIND_WRITE) || (bit_ff == ACK_SLOT));
   assign cmd_pop = cmd_valid && (!busy_ff || (step && last));

   always_comb begin
      scl_in = scl_ff;
      sda_in = sda_ff;
      drv_in = drv_ff;
      ack_in = 1'b0;
      case (kind_ff)
         KIND_START: begin
            case (sub_ff)
               PH_SET: begin
                  scl_in = 1'b1;
                  sda_in = 1'b1;
               end
               PH_HIGH: sda_in = 1'b0;
               default: scl_in = 1'b0;
            endcase
         end
         KIND_STOP: begin
            case (sub_ff)
               PH_SET:  sda_in = 1'b0;
               PH_HIGH: scl_in = 1'b1;
               default: sda_in = 1'b1;
            endcase
         end
         KIND_WRITE: begin
            if (bit_ff == ACK_SLOT) begin
               // Release data to the pull-up, clock the acknowledge, drive again.
               case (sub_ff)
                  PH_SET: begin
                     drv_in = 1'b0;
                     sda_in = 1'b1;
                  end
                  PH_HIGH: scl_in = 1'b1;
                  default: begin
                     scl_in = 1'b0;
                     drv_in = 1'b1;
                     ack_in = ack_ff;
                  end
               endcase
            end else begin
               case (sub_ff)
                  PH_SET:  sda_in = byte_ff[BITS_PER_BYTE-1];
                  PH_HIGH: scl_in = 1'b1;
                  default: scl_in = 1'b0;
               endcase
            end
         end
         default: begin
            scl_in = scl_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         drv_ff       <= 1'b1;
      end else begin
         if (cmd_pop) begin
            busy_ff <= 1'b1;
         end else if (step && last) begin
            busy_ff <= 1'b0;
         end
         if (step) begin
            scl_ff       <= scl_in;
            sda_ff       <= sda_in;
            drv_ff       <= drv_in;
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         kind_ff <= cmd.kind;
         byte_ff <= cmd.data_byte;
         ack_ff  <= cmd.sda_sample;
         sub_ff  <= PH_SET;
         bit_ff  <= '0;
      end else if (step) begin
         case (sub_ff)
            PH_SET:  sub_ff <= PH_HIGH;
            PH_HIGH: sub_ff <= PH_LOW;
            default: begin
               // Advance to the next bit slot.
               sub_ff  <= PH_SET;
               bit_ff  <= bit_ff + 1'b1;
               byte_ff <= {byte_ff[BITS_PER_BYTE-2:0], 1'b0};
            end
         endcase
      end
      if (step) begin
         out_scl_ff  <= scl_in;
         out_sda_ff  <= sda_in;
         out_drv_ff  <= drv_in;
         out_ack_ff  <= ack_in;
         out_last_ff <= last;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.scl_level  = out_scl_ff;
   assign rsp.sda_level  = out_sda_ff;
   assign rsp.sda_drive  = out_drv_ff;
   assign rsp.ack_level  = out_ack_ff;
   assign rsp.last_phase = out_last_ff;

   a_bit_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> bit_ff <= ACK_SLOT)
      else $error("bit slot beyond acknowledge");

   a_drive_restored: assert property (@(posedge clock) disable iff (reset)
      (step && last) |=> drv_ff)
      else $error("data line left released after command");

   a_release_only_ack: assert property (@(posedge clock) disable iff (reset)
      !drv_ff |-> (busy_ff && kind_ff == KIND_WRITE && bit_ff == ACK_SLOT))
      else $error("data line released outside acknowledge clock");

endmodule

### verif/i2c_master_byte_writer_unit_test.sv
// Self-checking testbench for the I2C write-only master pin sequencer.
`timescale 1ns / 100ps

module i2c_master_byte_writer_unit_test;
   import i2cmbw_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int RANDOM_PER_PHASE = 80;
   localparam int SETTLE_CYCLES    = 40;
   localparam int DIRECTED_ROWS    = 20;

   typedef struct packed {
      logic scl;
      logic sda;
      logic drv;
      logic ack;
      logic last;
   } pin_phase_type;

   typedef struct packed {
      logic [1:0]               kind;
      logic [BITS_PER_BYTE-1:0] data_byte;
      logic                     sda_sample;
      logic                     typed_on;
      pin_phase_type            typed_end;
   } cmd_row_type;

   // Final phase of each command, as the line levels must end up.
   localparam pin_phase_type END_START   =
      '{scl: 1'b0, sda: 1'b0, drv: 1'b1, ack: 1'b0, last: 1'b1};
   localparam pin_phase_type END_STOP    =
      '{scl: 1'b1, sda: 1'b1, drv: 1'b1, ack: 1'b0, last: 1'b1};
   localparam pin_phase_type END_WR_ACK  =
      '{scl: 1'b0, sda: 1'b1, drv: 1'b1, ack: 1'b0, last: 1'b1};
   localparam pin_phase_type END_WR_NACK =
      '{scl: 1'b0, sda: 1'b1, drv: 1'b1, ack: 1'b1, last: 1'b1};
   localparam pin_phase_type NO_END      = '0;

   logic clock = 1'b0;
   logic reset;

   i2cmbw_req_if req_bus ();
   i2cmbw_rsp_if rsp_bus ();

   i2c_master_byte_writer_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Sideband that travels with each request: a hand-typed final phase.
   logic          typed_valid;
   pin_phase_type typed_final;

   int sender_idle_pct;
   int receiver_stall_pct;
   int mismatch_count;

   // Predicted line state.
   logic line_scl = 1'b1;
   logic line_sda = 1'b1;
   logic line_drv = 1'b1;

   pin_phase_type expected_phases[$];
   cmd_row_type   directed_rows[DIRECTED_ROWS];

   function automatic void queue_phase(input logic ack, input logic last);
      expected_phases.push_back(pin_phase_type'{scl: line_scl, sda: line_sda, drv: line_drv,
                                                ack: ack, last: last});
   endfunction

   task automatic predict_phases(input logic [1:0] kind,
                                 input logic [BITS_PER_BYTE-1:0] data_byte,
                                 input logic sda_sample);
      logic [BITS_PER_BYTE-1:0] shifter;
      shifter = data_byte;
      case (kind)
         KIND_START: begin
            line_sda = 1'b1;
            line_scl = 1'b1;
            queue_phase(1'b0, 1'b0);
            line_sda = 1'b0;
            queue_phase(1'b0, 1'b0);
            line_scl = 1'b0;
            queue_phase(1'b0, 1'b1);
         end
         KIND_STOP: begin
            line_sda = 1'b0;
            queue_phase(1'b0, 1'b0);
            line_scl = 1'b1;
            queue_phase(1'b0, 1'b0);
            line_sda = 1'b1;
            queue_phase(1'b0, 1'b1);
         end
         KIND_WRITE: begin
            for (int i = 0; i < BITS_PER_BYTE; i++) begin
               line_sda = shifter[BITS_PER_BYTE-1];
               shifter  = shifter << 1;
               queue_phase(1'b0, 1'b0);
               line_scl = 1'b1;
               queue_phase(1'b0, 1'b0);
               line_scl = 1'b0;
               queue_phase(1'b0, 1'b0);
            end
            // release for the acknowledge clock, then drive again
            line_drv = 1'b0;
            line_sda = 1'b1;
            queue_phase(1'b0, 1'b0);
            line_scl = 1'b1;
            queue_phase(1'b0, 1'b0);
            line_scl = 1'b0;
            line_drv = 1'b1;
            queue_phase(sda_sample, 1'b1);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      pin_phase_type got;
      pin_phase_type want;
      if (!reset) begin
         // check before predicting so a response never meets its own request
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{scl: rsp_bus.scl_level, sda: rsp_bus.sda_level, drv: rsp_bus.sda_drive,
                    ack: rsp_bus.ack_level, last: rsp_bus.last_phase};
            if (expected_phases.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected response: scl=%b sda=%b drive=%b ack=%b last=%b",
                           got.scl, got.sda, got.drv, got.ack, got.last);
               mismatch_count++;
            end else begin
               want = expected_phases.pop_front();
               if (got.scl !== want.scl || got.sda !== want.sda || got.drv !== want.drv ||
                   got.ack !== want.ack || got.last !== want.last) begin
                  if (mismatch_count < 10) begin
                     $display("mismatch at %0t: expected scl=%b sda=%b drive=%b ack=%b last=%b",
                              $realtime, want.scl, want.sda, want.drv, want.ack, want.last);
                     $display("   got scl=%b sda=%b drive=%b ack=%b last=%b",
                              got.scl, got.sda, got.drv, got.ack, got.last);
                  end
                  mismatch_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_phases(req_bus.kind, req_bus.data_byte, req_bus.sda_sample);
            if (typed_valid && req_bus.kind != KIND_UNUSED)
               expected_phases[expected_phases.size()-1] = typed_final;
         end
      end
   end

   task automatic send_cmd(input logic [1:0] kind, input logic [BITS_PER_BYTE-1:0] data_byte,
                           input logic sda_sample, input logic typed_on,
                           input pin_phase_type typed_end);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid      <= 1'b0;
         req_bus.kind       <= 2'($urandom);
         req_bus.data_byte  <= BITS_PER_BYTE'($urandom);
         req_bus.sda_sample <= 1'($urandom);
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= kind;
      req_bus.data_byte  <= data_byte;
      req_bus.sda_sample <= sda_sample;
      typed_valid        <= typed_on;
      typed_final        <= typed_end;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Hold the sender until every expected phase has come out.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_phases.size() != 0) @(posedge clock);
   endtask

   task automatic run_random(input int idle_pct, input int stall_pct);
      int         sent;
      int         writes;
      logic [1:0] kind;
      sender_idle_pct    <= idle_pct;
      receiver_stall_pct <= stall_pct;
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
         if ($urandom_range(99) < 75) begin
            // well-formed transfer: start, a few bytes, stop
            send_cmd(KIND_START, BITS_PER_BYTE'($urandom), 1'($urandom), 1'b0, NO_END);
            writes = $urandom_range(1, 4);
            for (int i = 0; i < writes; i++)
               send_cmd(KIND_WRITE, BITS_PER_BYTE'($urandom), 1'($urandom), 1'b0, NO_END);
            send_cmd(KIND_STOP, BITS_PER_BYTE'($urandom), 1'($urandom), 1'b0, NO_END);
            sent += writes + 2;
         end else begin
            kind = 2'($urandom_range(3));
            send_cmd(kind, BITS_PER_BYTE'($urandom), 1'($urandom), 1'b0, NO_END);
            if (kind != KIND_UNUSED)
               sent++;
         end
      end
   endtask

   initial begin
      directed_rows = '{
         '{KIND_START,  8'h00, 1'b0, 1'b1, END_START},
         '{KIND_WRITE,  8'hFF, 1'b0, 1'b1, END_WR_ACK},
         '{KIND_WRITE,  8'h00, 1'b1, 1'b1, END_WR_NACK},
         '{KIND_STOP,   8'h00, 1'b0, 1'b1, END_STOP},
         '{KIND_STOP,   8'hFF, 1'b1, 1'b1, END_STOP},
         '{KIND_START,  8'hFF, 1'b1, 1'b1, END_START},
         '{KIND_START,  8'h00, 1'b0, 1'b0, NO_END},
         '{KIND_WRITE,  8'hA5, 1'b0, 1'b0, NO_END},
         '{KIND_WRITE,  8'h5A, 1'b1, 1'b0, NO_END},
         '{KIND_UNUSED, 8'hFF, 1'b1, 1'b0, NO_END},
         '{KIND_WRITE,  8'h80, 1'b1, 1'b0, NO_END},
         '{KIND_WRITE,  8'h01, 1'b0, 1'b0, NO_END},
         '{KIND_UNUSED, 8'h00, 1'b0, 1'b0, NO_END},
         '{KIND_STOP,   8'h00, 1'b0, 1'b0, NO_END},
         '{KIND_WRITE,  8'h7F, 1'b1, 1'b0, NO_END},
         '{KIND_WRITE,  8'hFE, 1'b0, 1'b0, NO_END},
         '{KIND_UNUSED, 8'h55, 1'b1, 1'b0, NO_END},
         '{KIND_START,  8'hAA, 1'b0, 1'b0, NO_END},
         '{KIND_STOP,   8'h55, 1'b1, 1'b0, NO_END},
         '{KIND_START,  8'h00, 1'b0, 1'b0, NO_END}
      };
      mismatch_count     = 0;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.kind       <= KIND_START;
      req_bus.data_byte  <= '0;
      req_bus.sda_sample <= 1'b0;
      typed_valid        <= 1'b0;
      typed_final        <= NO_END;
      sender_idle_pct    <= 0;
      receiver_stall_pct <= 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_cmd(directed_rows[i].kind, directed_rows[i].data_byte,
                  directed_rows[i].sda_sample, directed_rows[i].typed_on,
                  directed_rows[i].typed_end);
      wait_drained();

      run_random(0, 0);
      wait_drained();
      run_random(69, 0);
      wait_drained();
      run_random(0, 69);
      wait_drained();
      run_random(15, 15);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_phases.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
